// ----- rtl/core/fpow_pkg.sv -----
// Shared types and constants for the binary64 power-by-squaring core.
package fpow_pkg;

    localparam int EXP_WIDTH = 32;
    localparam int CNT_W     = $clog2(EXP_WIDTH + 1);

    localparam logic [63:0] F64_ONE      = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] F64_QBIT     = 64'h0008_0000_0000_0000;
    localparam logic [63:0] F64_DFLT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0] F64_EXP_MAX  = 11'h7FF;
    // Magnitude bits of the binary64 value 1e-6.
    localparam logic [62:0] NEAR_ZERO_LIM = 63'h3EB0_C6F7_A0B5_ED8D;

    typedef enum logic [0:0] {
        FOP_MUL   = 1'b0,
        FOP_RECIP = 1'b1
    } t_fop;

    typedef struct packed {
        logic start;
        t_fop op;
    } t_fpu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_fpu_rsp;

endpackage

// ----- rtl/core/float_power_by_squaring_core.sv -----
// Top level of the binary64 power-by-squaring core: request port and squaring sequencer.
//
// Channel  | Direction | Ports                             | Handshake
// ---------+-----------+-----------------------------------+------------------------------
// request  | in        | i_base_bits, i_exponent           | taken when start & !busy
// result   | out       | o_result_bits                     | o_result_valid, one cycle
//
// A request with a zero exponent, or a near-zero base with a negative exponent, is answered
// in the cycle right after the edge that takes it. Otherwise the sequencer first shifts out
// the leading zeros of the exponent magnitude and its leading one, then for each lower bit
// issues one square and, for a set bit, one multiply by the base on the shared binary64
// unit; an operation with a zero, infinite or NaN operand ends after unpacking, and
// subnormal operands add normalization steps. A negative exponent adds one reciprocal.
// The unit is the bottleneck: one request is in flight at a time and busy stays high
// through the result strobe cycle. Reset is synchronous and active low and returns the
// core to idle.
// The receiver cannot stall; each result is shown for exactly one cycle.
module float_power_by_squaring_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [63:0]                         i_base_bits,
    input  logic signed [fpow_pkg::EXP_WIDTH-1:0] i_exponent,
    output logic                                o_result_valid,
    output logic [63:0]                         o_result_bits
);
    import fpow_pkg::*;

    typedef enum logic [7:0] {
        T_IDLE = 8'b00000001,
        T_FIND = 8'b00000010,
        T_LOOP = 8'b00000100,
        T_SQ   = 8'b00001000,
        T_BIT  = 8'b00010000,
        T_MB   = 8'b00100000,
        T_RCP  = 8'b01000000,
        T_OUT  = 8'b10000000
    } t_tst;

    t_tst                 r_st;
    logic [63:0]          r_base, r_acc, r_res;
    logic [EXP_WIDTH-1:0] r_mag;
    logic [CNT_W-1:0]     r_bits;
    logic                 r_neg;

    // Magnitude of the exponent; the most negative value maps to 2^(EXP_WIDTH-1).
    logic [EXP_WIDTH-1:0] in_mag;
    logic                 in_neg, in_near, accept;
    always_comb begin
        in_neg  = i_exponent[EXP_WIDTH-1];
        in_mag  = in_neg ? (~i_exponent + 1'b1) : i_exponent;
        in_near = (i_base_bits[62:0] < NEAR_ZERO_LIM);
        accept  = start && !busy;
    end

    t_fpu_req    fpu_req;
    t_fpu_rsp    fpu_rsp;
    logic [63:0] fpu_res, fpu_b;

    // The sequencer issues a square, a multiply by the base, or the final reciprocal.
    always_comb begin
        fpu_req.start = 1'b0;
        fpu_req.op    = FOP_MUL;
        fpu_b         = r_acc;
        if (r_st == T_LOOP) begin
            if (r_bits != '0) begin
                fpu_req.start = 1'b1;
            end else if (r_neg) begin
                fpu_req.start = 1'b1;
                fpu_req.op    = FOP_RECIP;
            end
        end else if ((r_st == T_BIT) && r_mag[EXP_WIDTH-1]) begin
            fpu_req.start = 1'b1;
            fpu_b         = r_base;
        end
    end

    fpow_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_a     (r_acc),
        .i_b     (fpu_b),
        .o_rsp   (fpu_rsp),
        .o_res   (fpu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= T_IDLE;
        end else begin
            unique case (r_st)
                T_IDLE: begin
                    if (accept) begin
                        r_base <= i_base_bits;
                        r_acc  <= i_base_bits;
                        r_neg  <= in_neg;
                        r_mag  <= in_mag;
                        r_bits <= CNT_W'(EXP_WIDTH);
                        if (in_neg && in_near) begin
                            r_res <= 64'd0;
                            r_st  <= T_OUT;
                        end else if (in_mag == '0) begin
                            r_res <= F64_ONE;
                            r_st  <= T_OUT;
                        end else begin
                            r_st <= T_FIND;
                        end
                    end
                end
                T_FIND: begin
                    // Drop leading zeros and the leading one itself.
                    r_mag  <= r_mag << 1;
                    r_bits <= r_bits - 1'b1;
                    if (r_mag[EXP_WIDTH-1]) begin
                        r_st <= T_LOOP;
                    end
                end
                T_LOOP: begin
                    if (r_bits != '0) begin
                        r_st <= T_SQ;
                    end else if (r_neg) begin
                        r_st <= T_RCP;
                    end else begin
                        r_res <= r_acc;
                        r_st  <= T_OUT;
                    end
                end
                T_SQ: begin
                    if (fpu_rsp.done) begin
                        r_acc <= fpu_res;
                        r_st  <= T_BIT;
                    end
                end
                T_BIT: begin
                    if (r_mag[EXP_WIDTH-1]) begin
                        r_st <= T_MB;
                    end else begin
                        r_mag  <= r_mag << 1;
                        r_bits <= r_bits - 1'b1;
                        r_st   <= T_LOOP;
                    end
                end
                T_MB: begin
                    if (fpu_rsp.done) begin
                        r_acc  <= fpu_res;
                        r_mag  <= r_mag << 1;
                        r_bits <= r_bits - 1'b1;
                        r_st   <= T_LOOP;
                    end
                end
                T_RCP: begin
                    if (fpu_rsp.done) begin
                        r_res <= fpu_res;
                        r_st  <= T_OUT;
                    end
                end
                T_OUT: begin
                    r_st <= T_IDLE;
                end
                default: r_st <= T_IDLE;
            endcase
        end
    end

    assign busy           = (r_st != T_IDLE);
    assign o_result_valid = (r_st == T_OUT);
    assign o_result_bits  = r_res;

    // The unit is only started when it is free.
    a_fpu_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_req.start |-> !fpu_rsp.busy)
        else $error("shared unit started while busy");

    // A finished operation only arrives while the sequencer waits for it.
    a_fpu_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_rsp.done |-> ((r_st == T_SQ) || (r_st == T_MB) || (r_st == T_RCP)))
        else $error("unit result arrived outside a wait state");

    // A taken request raises busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after a request");

    // After the result strobe the core is ready again.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy && !o_result_valid)
        else $error("core not idle after result");

endmodule

// ----- rtl/core/fpow_fpu.sv -----
// Shared iterative binary64 unit: multiply and reciprocal with round to nearest even.
module fpow_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpow_pkg::t_fpu_req i_req,
    input  logic [63:0]       i_a,
    input  logic [63:0]       i_b,
    output fpow_pkg::t_fpu_rsp o_rsp,
    output logic [63:0]       o_res
);
    import fpow_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE  = 7'b0000001,
        F_UNPK  = 7'b0000010,
        F_NORM  = 7'b0000100,
        F_MUL   = 7'b0001000,
        F_DIV   = 7'b0010000,
        F_ALIGN = 7'b0100000,
        F_ROUND = 7'b1000000
    } t_fst;

    t_fst               r_st;
    t_fop               r_op;
    logic [63:0]        r_a, r_b, r_res;
    logic               r_sign, r_done, r_sticky;
    logic [52:0]        r_ma, r_mb;
    logic signed [13:0] r_ea, r_eb, r_ue;
    logic [105:0]       r_acc;
    logic [53:0]        r_rem;
    logic [53:0]        r_pp;
    logic [5:0]         r_cnt;
    logic [11:0]        r_be;

    function automatic logic [4:0] norm_sh(input logic [52:0] m);
        logic [4:0] s;
        if (m[52:37] == 16'd0) begin
            s = 5'd16;
        end else if (m[52:49] == 4'd0) begin
            s = 5'd4;
        end else begin
            s = 5'd1;
        end
        return s;
    endfunction

    // Operand classification.
    logic [10:0] a_exp, b_exp, a_eff, b_eff;
    logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, mul_sign;
    always_comb begin
        a_exp    = r_a[62:52];
        b_exp    = r_b[62:52];
        a_nan    = (a_exp == F64_EXP_MAX) && (r_a[51:0] != 52'd0);
        a_inf    = (a_exp == F64_EXP_MAX) && (r_a[51:0] == 52'd0);
        a_zero   = (r_a[62:0] == 63'd0);
        b_nan    = (b_exp == F64_EXP_MAX) && (r_b[51:0] != 52'd0);
        b_inf    = (b_exp == F64_EXP_MAX) && (r_b[51:0] == 52'd0);
        b_zero   = (r_b[62:0] == 63'd0);
        a_eff    = (a_exp == 11'd0) ? 11'd1 : a_exp;
        b_eff    = (b_exp == 11'd0) ? 11'd1 : b_exp;
        mul_sign = r_a[63] ^ r_b[63];
    end

    // Shared 27x27 partial product.
    logic [26:0] pp_x, pp_y;
    logic [53:0] pp;
    always_comb begin
        case (r_cnt[1:0])
            2'd0:    begin pp_x = r_ma[26:0];         pp_y = r_mb[26:0];         end
            2'd1:    begin pp_x = r_ma[26:0];         pp_y = {1'b0, r_mb[52:27]}; end
            2'd2:    begin pp_x = {1'b0, r_ma[52:27]}; pp_y = r_mb[26:0];         end
            default: begin pp_x = {1'b0, r_ma[52:27]}; pp_y = {1'b0, r_mb[52:27]}; end
        endcase
        pp = pp_x * pp_y;
    end

    logic [105:0] pp_al;
    always_comb begin
        case (r_cnt) inside
            6'd1:       pp_al = {52'd0, r_pp};
            6'd2, 6'd3: pp_al = {25'd0, r_pp, 27'd0};
            default:    pp_al = {r_pp[51:0], 54'd0};
        endcase
    end

    // Divider step.
    logic [53:0] div_diff, div_rem;
    logic        div_ge;
    always_comb begin
        div_ge   = r_rem >= {1'b0, r_ma};
        div_diff = r_rem - {1'b0, r_ma};
        div_rem  = div_ge ? div_diff : r_rem;
    end

    // Alignment: leading one to the top, then right shift into the subnormal range.
    logic [105:0]       al_m, al_sh;
    logic signed [13:0] al_ue, al_be, al_d;
    logic [5:0]         al_s;
    logic               al_st0, al_lost;
    logic [11:0]        al_bec;
    always_comb begin
        if (r_op == FOP_MUL) begin
            al_m   = r_acc[105] ? r_acc : {r_acc[104:0], 1'b0};
            al_ue  = r_ue + {13'd0, r_acc[105]};
            al_st0 = 1'b0;
        end else begin
            al_m   = r_acc[55] ? {r_acc[55:0], 50'd0} : {r_acc[54:0], 51'd0};
            al_ue  = 14'sd0 - r_ea - {13'd0, ~r_acc[55]};
            al_st0 = (r_rem != 54'd0);
        end
        al_be = al_ue + 14'sd1023;
        al_d  = 14'sd1 - al_be;
        if (!al_be[13] && (al_be != 14'sd0)) begin
            al_s   = 6'd0;
            al_bec = al_be[11:0];
        end else begin
            al_s   = (al_d > 14'sd56) ? 6'd56 : al_d[5:0];
            al_bec = 12'd1;
        end
        al_sh   = al_m >> al_s;
        al_lost = |(al_m & ~({106{1'b1}} << al_s));
    end

    // Rounding.
    logic [52:0] rd_m;
    logic [53:0] rd_v;
    logic        rd_inc;
    logic [12:0] rd_ex;
    logic [51:0] rd_fr;
    logic [63:0] rd_res;
    always_comb begin
        rd_m   = r_acc[105:53];
        rd_inc = r_acc[52] & ((|r_acc[51:0]) | r_sticky | rd_m[0]);
        rd_v   = {1'b0, rd_m} + {53'd0, rd_inc};
        if (rd_v[53]) begin
            rd_ex = {1'b0, r_be} + 13'd1;
            rd_fr = 52'd0;
        end else begin
            rd_ex = rd_v[52] ? {1'b0, r_be} : 13'd0;
            rd_fr = rd_v[51:0];
        end
        if (rd_ex >= {2'b0, F64_EXP_MAX}) begin
            rd_res = {r_sign, F64_EXP_MAX, 52'd0};
        end else begin
            rd_res = {r_sign, rd_ex[10:0], rd_fr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= F_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                F_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        r_a  <= i_a;
                        r_b  <= i_b;
                        r_st <= F_UNPK;
                    end
                end
                F_UNPK: begin
                    r_ma <= {a_exp != 11'd0, r_a[51:0]};
                    r_mb <= {b_exp != 11'd0, r_b[51:0]};
                    r_ea <= $signed({3'b0, a_eff}) - 14'sd1023;
                    r_eb <= $signed({3'b0, b_eff}) - 14'sd1023;
                    r_st <= F_IDLE;
                    r_done <= 1'b1;
                    if (r_op == FOP_MUL) begin
                        r_sign <= mul_sign;
                        if (a_nan) begin
                            r_res <= r_a | F64_QBIT;
                        end else if (b_nan) begin
                            r_res <= r_b | F64_QBIT;
                        end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                            r_res <= F64_DFLT_NAN;
                        end else if (a_inf || b_inf) begin
                            r_res <= {mul_sign, F64_EXP_MAX, 52'd0};
                        end else if (a_zero || b_zero) begin
                            r_res <= {mul_sign, 63'd0};
                        end else begin
                            r_st   <= F_NORM;
                            r_done <= 1'b0;
                        end
                    end else begin
                        r_sign <= r_a[63];
                        if (a_nan) begin
                            r_res <= r_a | F64_QBIT;
                        end else if (a_inf) begin
                            r_res <= {r_a[63], 63'd0};
                        end else if (a_zero) begin
                            r_res <= {r_a[63], F64_EXP_MAX, 52'd0};
                        end else begin
                            r_st   <= F_NORM;
                            r_done <= 1'b0;
                        end
                    end
                end
                F_NORM: begin
                    r_cnt <= 6'd0;
                    r_acc <= 106'd0;
                    if (!r_ma[52]) begin
                        r_ma <= r_ma << norm_sh(r_ma);
                        r_ea <= r_ea - $signed({9'd0, norm_sh(r_ma)});
                    end else if ((r_op == FOP_MUL) && !r_mb[52]) begin
                        r_mb <= r_mb << norm_sh(r_mb);
                        r_eb <= r_eb - $signed({9'd0, norm_sh(r_mb)});
                    end else if (r_op == FOP_MUL) begin
                        r_ue <= r_ea + r_eb;
                        r_st <= F_MUL;
                    end else begin
                        r_rem <= {2'b01, 52'd0};
                        r_st  <= F_DIV;
                    end
                end
                F_MUL: begin
                    r_pp  <= pp;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt != 6'd0) begin
                        r_acc <= r_acc + pp_al;
                    end
                    if (r_cnt == 6'd4) begin
                        r_st <= F_ALIGN;
                    end
                end
                F_DIV: begin
                    r_rem <= {div_rem[52:0], 1'b0};
                    r_acc <= {r_acc[104:0], div_ge};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd55) begin
                        r_st <= F_ALIGN;
                    end
                end
                F_ALIGN: begin
                    r_acc    <= al_sh;
                    r_sticky <= al_lost | al_st0;
                    r_be     <= al_bec;
                    r_st     <= F_ROUND;
                end
                F_ROUND: begin
                    r_res  <= rd_res;
                    r_done <= 1'b1;
                    r_st   <= F_IDLE;
                end
                default: r_st <= F_IDLE;
            endcase
        end
    end

    assign o_rsp.busy = (r_st != F_IDLE);
    assign o_rsp.done = r_done;
    assign o_res      = r_res;

endmodule

// ----- verif/tb_float_power_by_squaring_core.sv -----
// Self-checking testbench for the binary64 power-by-squaring core.
module tb_float_power_by_squaring_core;
    import fpow_pkg::*;

    typedef struct {
        logic [63:0]          base_bits;
        logic [EXP_WIDTH-1:0] exponent;
        int                   gap;
    } t_pow_req;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [63:0]          i_base_bits;
    logic [EXP_WIDTH-1:0] i_exponent;
    logic                 o_result_valid;
    logic [63:0]          o_result_bits;

    t_pow_req    pending_reqs[$];
    logic [63:0] expected_powers[$];
    int          mismatch_count;
    int          orphan_count;
    int          idle_cycles;
    bit          stimulus_done;
    bit          reset_done;

    float_power_by_squaring_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_base_bits    (i_base_bits),
        .i_exponent     (i_exponent),
        .o_result_valid (o_result_valid),
        .o_result_bits  (o_result_bits)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // The core rounds each binary64 operation to nearest even, just as the simulator's real
    // arithmetic does, so the predictor works directly on real values.
    function automatic logic [63:0] predict_power(logic [63:0] base_bits,
                                                  logic [EXP_WIDTH-1:0] exp_bits);
        logic [EXP_WIDTH-1:0] mag_n;
        logic [63:0] mag;
        logic [63:0] pbits;
        real         base;
        real         acc;
        int          top;
        bit          neg;
        neg   = exp_bits[EXP_WIDTH-1];
        mag_n = neg ? (~exp_bits + 1'b1) : exp_bits;
        // The most negative exponent wraps to itself here; zero-extending keeps it positive.
        mag   = 64'(mag_n);
        base = $bitstoreal(base_bits);
        if (neg && base < 1e-6 && (0.0 - base) < 1e-6)
            return 64'h0;
        if (mag == 64'h0)
            return F64_ONE;
        top = 63;
        while (top > 0 && !mag[top])
            top--;
        acc = base;
        for (int i = top - 1; i >= 0; i--) begin
            acc = acc * acc;
            if (mag[i])
                acc = acc * base;
        end
        pbits = $realtobits(acc);
        if (!neg)
            return pbits;
        // The reciprocal of a signed zero is an infinity with that sign.
        if (pbits[62:0] == 63'h0)
            return {pbits[63], 63'h7FF0_0000_0000_0000};
        return $realtobits(1.0 / acc);
    endfunction

    // NaN payloads may legitimately differ, so any NaN is accepted for an expected NaN.
    function automatic bit is_nan(logic [63:0] b);
        return b[62:52] == F64_EXP_MAX && b[51:0] != 52'h0;
    endfunction

    task automatic push_request(logic [63:0] base_bits, logic [EXP_WIDTH-1:0] exp_bits);
        t_pow_req r;
        r.base_bits = base_bits;
        r.exponent  = exp_bits;
        r.gap       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] random_base();
        logic [63:0] b;
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: b = b;                                       // raw pattern, any class
            1: b[62:52] = 11'h0;                            // subnormal or zero
            2: b = {b[63], 11'h3EB + 11'($urandom_range(0, 1)), b[51:0]}; // near 1e-6
            default: b[62:52] = 11'h3FF - 11'h3 + 11'($urandom_range(0, 6));
        endcase
        return b;
    endfunction

    function automatic logic [EXP_WIDTH-1:0] random_exponent();
        logic [EXP_WIDTH-1:0] e;
        e = $urandom;
        case ($urandom_range(0, 7))
            0: e = e;
            1: e = $signed(EXP_WIDTH'($urandom_range(0, 2000))) - 1000;
            default: e = $signed(EXP_WIDTH'($urandom_range(0, 80))) - 40;
        endcase
        return e;
    endfunction

    // The driver presents one request at a time and waits a drawn gap before the next.
    int       gap_left;
    bit       have_req;
    bit       driving;
    bit       req_taken;
    t_pow_req cur_req;

    always @(negedge i_clk) begin
        if (!reset_done) begin
            start <= 1'b0;
        end else begin
            if (req_taken) begin
                // The request was taken at the last rising edge.
                req_taken = 1'b0;
                have_req  = 1'b0;
                driving   = 1'b0;
            end
            if (!have_req && pending_reqs.size() > 0) begin
                cur_req  = pending_reqs.pop_front();
                have_req = 1'b1;
                gap_left = cur_req.gap;
            end
            if (have_req && !driving) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    i_base_bits <= cur_req.base_bits;
                    i_exponent  <= cur_req.exponent;
                    driving     = 1'b1;
                end
            end
            start <= driving;
        end
    end

    // The monitor records accepted requests and checks every result strobe at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles = idle_cycles + 1;
            if (start && !busy) begin
                expected_powers.push_back(predict_power(i_base_bits, i_exponent));
                req_taken   = 1'b1;
                idle_cycles = 0;
            end
            if (o_result_valid) begin
                idle_cycles = 0;
                if (expected_powers.size() == 0) begin
                    orphan_count++;
                    $display("Unexpected result %h with no request waiting", o_result_bits);
                end else begin
                    logic [63:0] want;
                    want = expected_powers.pop_front();
                    if (!(is_nan(want) ? is_nan(o_result_bits) : want == o_result_bits)) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("Result mismatch: expected %h, got %h",
                                     want, o_result_bits);
                    end
                end
            end
        end
    end

    initial begin
        start          = 1'b0;
        i_base_bits    = 64'h0;
        i_exponent     = '0;
        i_rst_n        = 1'b0;
        reset_done     = 1'b0;
        mismatch_count = 0;
        orphan_count   = 0;
        idle_cycles    = 0;
        have_req       = 1'b0;

        // Directed requests: exponent extremes, zero and near-zero bases, NaN, overflow,
        // underflow.
        push_request(F64_ONE, '0);
        push_request(64'h7FF8_0000_0000_0001, '0);            // NaN to the zero power
        push_request(64'h7FF4_0000_0000_0000, 3);              // NaN propagates
        push_request(64'h0, -1);                               // +0 with negative power
        push_request(64'h8000_0000_0000_0000, -5);             // -0 with negative power
        push_request(64'h3EB0_C6F7_A0B5_ED8C, -2);             // just below 1e-6
        push_request(64'h3EB0_C6F7_A0B5_ED8D, -2);             // exactly 1e-6
        push_request(64'hBEB0_C6F7_A0B5_ED8C, -3);             // just above -1e-6
        push_request(64'h4000_0000_0000_0000, {1'b1, {(EXP_WIDTH-1){1'b0}}}); // most negative
        push_request(64'h3FF0_0000_0000_0001, {1'b0, {(EXP_WIDTH-1){1'b1}}}); // most positive
        push_request(64'hBFF0_0000_0000_0000, {1'b0, {(EXP_WIDTH-1){1'b1}}});
        push_request(64'h3EC0_0000_0000_0000, -40);            // small power, then its reciprocal
        push_request(64'hBEC0_0000_0000_0000, -41);            // small negative power, then its reciprocal
        push_request(64'h7FEF_FFFF_FFFF_FFFF, 2);              // overflow to infinity
        push_request(64'h7FF0_0000_0000_0000, -1);             // reciprocal of infinity
        push_request(64'h0000_0000_0000_0001, 1);              // smallest subnormal
        push_request(64'h0000_0000_0000_0001, 2);
        push_request(64'h000F_FFFF_FFFF_FFFF, -1);
        push_request(64'hFFFF_FFFF_FFFF_FFFF, -1);
        push_request(64'h4008_0000_0000_0000, 13);
        push_request(64'hC008_0000_0000_0000, -7);
        push_request(64'h3FF8_0000_0000_0000, 1);
        for (int n = 0; n < 1650; n++)
            push_request(random_base(), random_exponent());

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n    = 1'b1;
        reset_done = 1'b1;

        fork
            begin
                wait (pending_reqs.size() == 0 && !have_req && expected_powers.size() == 0);
                repeat (50) @(posedge i_clk);
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        join_any
        if (mismatch_count == 0 && orphan_count == 0 && expected_powers.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
